/* hw/rtl/dnsa_pkg.sv */
package dnsa_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned IDX_W        = 4;

    localparam logic [7:0] QR_MASK      = 8'h80;
    localparam logic [7:0] RCODE_MASK   = 8'h0f;
    localparam logic [7:0] POINTER_MASK = 8'hc0;

    localparam logic [IDX_W-1:0] HDR_IDX_FLAGS_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] HDR_IDX_FLAGS_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] HDR_IDX_QD_HI    = IDX_W'(4);
    localparam logic [IDX_W-1:0] HDR_IDX_QD_LO    = IDX_W'(5);
    localparam logic [IDX_W-1:0] HDR_IDX_AN_HI    = IDX_W'(6);
    localparam logic [IDX_W-1:0] HDR_IDX_AN_LO    = IDX_W'(7);
    localparam logic [IDX_W-1:0] HDR_IDX_LAST     = IDX_W'(HEADER_BYTES - 1);

    localparam logic [IDX_W-1:0] QFIX_LAST  = IDX_W'(3);
    localparam logic [IDX_W-1:0] AFIX_TY_HI = IDX_W'(0);
    localparam logic [IDX_W-1:0] AFIX_TY_LO = IDX_W'(1);
    localparam logic [IDX_W-1:0] AFIX_DL_HI = IDX_W'(8);
    localparam logic [IDX_W-1:0] AFIX_DL_LO = IDX_W'(9);
    localparam logic [IDX_W-1:0] ADDR_LAST  = IDX_W'(3);

    localparam logic [15:0] TYPE_A  = 16'd1;
    localparam logic [15:0] LEN_A   = 16'd4;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_SHORT   = 3'd1,
        ST_HDR_ERR = 3'd2,
        ST_NO_ANS  = 3'd3,
        ST_NO_A    = 3'd4
    } status_t;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_QNAME  = 8'b0000_0010,
        PH_QFIXED = 8'b0000_0100,
        PH_ANAME  = 8'b0000_1000,
        PH_AFIXED = 8'b0001_0000,
        PH_ADATA  = 8'b0010_0000,
        PH_ADDR   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

endpackage

/* hw/rtl/dns_a_record_extractor.sv */
// A result is registered, valid the cycle after its end_of_packet byte is taken.
// Throughput: 1 byte per cycle; the parser state updates in a single pass per byte,
// and the output register lets a new byte in on the cycle a held result is taken.
// byte_stall is high only while a result is held and result_stall is high.
// Reset (rst_n low, asynchronous): parser returns to the header phase, no result.
module dns_a_record_extractor
    import dnsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  packet_byte,
    input  logic        end_of_packet,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [31:0] ipv4_address
);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] header_index_reg, header_index_next;
    logic [15:0]      questions_left_reg, questions_left_next;
    logic [15:0]      answers_left_reg, answers_left_next;
    logic [15:0]      skip_left_reg, skip_left_next;
    logic [IDX_W-1:0] fixed_index_reg, fixed_index_next;
    logic [15:0]      record_type_reg, record_type_next;
    logic [15:0]      data_length_reg, data_length_next;
    logic [31:0]      address_acc_reg, address_acc_next;
    status_t          verdict_reg, verdict_next;

    logic             result_valid_reg;
    status_t          status_reg, status_next;
    logic [31:0]      ipv4_address_reg, ipv4_address_next;

    logic             take;
    logic [15:0]      ans_dec;
    logic [15:0]      q_dec;
    logic [15:0]      skip_dec;
    logic [15:0]      dl_cur;
    phase_t           name_fixed;

    assign byte_stall = result_valid_reg & result_stall;
    assign take       = byte_valid & ~byte_stall;
    assign ans_dec    = answers_left_reg - 16'd1;
    assign q_dec      = questions_left_reg - 16'd1;
    assign skip_dec   = (skip_left_reg != 16'd0) ? skip_left_reg - 16'd1 : skip_left_reg;
    assign dl_cur     = (fixed_index_reg == AFIX_DL_LO) ? {data_length_reg[15:8], packet_byte}
                                                        : data_length_reg;
    assign name_fixed = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;

    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        questions_left_next = questions_left_reg;
        answers_left_next   = answers_left_reg;
        skip_left_next      = skip_left_reg;
        fixed_index_next    = fixed_index_reg;
        record_type_next    = record_type_reg;
        data_length_next    = data_length_reg;
        address_acc_next    = address_acc_reg;
        verdict_next        = verdict_reg;
        status_next         = status_reg;
        ipv4_address_next   = ipv4_address_reg;

        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_index_reg == HDR_IDX_FLAGS_HI && (packet_byte & QR_MASK) == 8'h00)
                        verdict_next = ST_HDR_ERR;
                    if (header_index_reg == HDR_IDX_FLAGS_LO && (packet_byte & RCODE_MASK) != 8'h00)
                        verdict_next = ST_HDR_ERR;
                    if (header_index_reg == HDR_IDX_QD_HI)
                        questions_left_next = {packet_byte, 8'h00};
                    if (header_index_reg == HDR_IDX_QD_LO)
                        questions_left_next = {questions_left_reg[15:8], packet_byte};
                    if (header_index_reg == HDR_IDX_AN_HI)
                        answers_left_next = {packet_byte, 8'h00};
                    if (header_index_reg == HDR_IDX_AN_LO)
                        answers_left_next = {answers_left_reg[15:8], packet_byte};
                    if (header_index_reg == HDR_IDX_LAST)
                    begin
                        priority if (verdict_reg != ST_FOUND)
                            phase_next = PH_DONE;
                        else if (answers_left_reg == 16'd0)
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = ST_NO_ANS;
                        end
                        else if (questions_left_reg == 16'd0)
                            phase_next = PH_ANAME;
                        else
                            phase_next = PH_QNAME;
                        skip_left_next = 16'd0;
                    end
                    header_index_next = header_index_reg + IDX_W'(1);
                end
                PH_QNAME, PH_ANAME:
                begin
                    priority if (skip_left_reg != 16'd0)
                        skip_left_next = skip_dec;
                    else if (packet_byte == 8'h00)
                    begin
                        phase_next       = name_fixed;
                        fixed_index_next = '0;
                    end
                    else if ((packet_byte & POINTER_MASK) == POINTER_MASK)
                    begin
                        phase_next       = name_fixed;
                        fixed_index_next = '0;
                        skip_left_next   = 16'd1;
                    end
                    else
                        skip_left_next = {8'h00, packet_byte};
                end
                PH_QFIXED:
                begin
                    priority if (skip_left_reg != 16'd0)
                        skip_left_next = skip_dec;
                    else if (fixed_index_reg >= QFIX_LAST)
                    begin
                        questions_left_next = q_dec;
                        phase_next          = (q_dec == 16'd0) ? PH_ANAME : PH_QNAME;
                        fixed_index_next    = '0;
                    end
                    else
                        fixed_index_next = fixed_index_reg + IDX_W'(1);
                end
                PH_AFIXED:
                begin
                    if (skip_left_reg != 16'd0)
                        skip_left_next = skip_dec;
                    else
                    begin
                        if (fixed_index_reg == AFIX_TY_HI)
                            record_type_next = {packet_byte, 8'h00};
                        if (fixed_index_reg == AFIX_TY_LO)
                            record_type_next = {record_type_reg[15:8], packet_byte};
                        if (fixed_index_reg == AFIX_DL_HI)
                            data_length_next = {packet_byte, 8'h00};
                        if (fixed_index_reg == AFIX_DL_LO)
                            data_length_next = dl_cur;
                        if (fixed_index_reg >= AFIX_DL_LO)
                        begin
                            fixed_index_next = '0;
                            priority if (record_type_reg == TYPE_A && dl_cur == LEN_A)
                            begin
                                phase_next       = PH_ADDR;
                                address_acc_next = 32'd0;
                            end
                            else if (dl_cur == 16'd0)
                            begin
                                answers_left_next = ans_dec;
                                if (ans_dec == 16'd0)
                                begin
                                    phase_next   = PH_DONE;
                                    verdict_next = ST_NO_A;
                                end
                                else
                                    phase_next = PH_ANAME;
                            end
                            else
                            begin
                                skip_left_next = dl_cur;
                                phase_next     = PH_ADATA;
                            end
                        end
                        else
                            fixed_index_next = fixed_index_reg + IDX_W'(1);
                    end
                end
                PH_ADATA:
                begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        answers_left_next = ans_dec;
                        if (ans_dec == 16'd0)
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = ST_NO_A;
                        end
                        else
                            phase_next = PH_ANAME;
                    end
                end
                PH_ADDR:
                begin
                    address_acc_next = {address_acc_reg[23:0], packet_byte};
                    if (fixed_index_reg >= ADDR_LAST)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = ST_FOUND;
                    end
                    else
                        fixed_index_next = fixed_index_reg + IDX_W'(1);
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            if (end_of_packet)
            begin
                priority if (phase_next == PH_HEADER)
                    status_next = ST_SHORT;
                else if (phase_next == PH_DONE)
                    status_next = verdict_next;
                else
                    status_next = ST_NO_A;
                ipv4_address_next = (status_next == ST_FOUND) ? address_acc_next : 32'd0;

                // new packet starts clean
                phase_next          = PH_HEADER;
                header_index_next   = '0;
                questions_left_next = 16'd0;
                answers_left_next   = 16'd0;
                skip_left_next      = 16'd0;
                fixed_index_next    = '0;
                record_type_next    = 16'd0;
                data_length_next    = 16'd0;
                address_acc_next    = 32'd0;
                verdict_next        = ST_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            header_index_reg   <= '0;
            questions_left_reg <= 16'd0;
            answers_left_reg   <= 16'd0;
            skip_left_reg      <= 16'd0;
            fixed_index_reg    <= '0;
            record_type_reg    <= 16'd0;
            data_length_reg    <= 16'd0;
            address_acc_reg    <= 32'd0;
            verdict_reg        <= ST_FOUND;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            questions_left_reg <= questions_left_next;
            answers_left_reg   <= answers_left_next;
            skip_left_reg      <= skip_left_next;
            fixed_index_reg    <= fixed_index_next;
            record_type_reg    <= record_type_next;
            data_length_reg    <= data_length_next;
            address_acc_reg    <= address_acc_next;
            verdict_reg        <= verdict_next;
            if (take && end_of_packet)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        ipv4_address_reg <= ipv4_address_next;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign ipv4_address = ipv4_address_reg;

endmodule

/* hw/rtl/dnsa_checker.sv */
module dnsa_checker
    import dnsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  packet_byte,
    input logic        end_of_packet,
    input logic        result_valid,
    input logic        result_stall,
    input logic [2:0]  status,
    input logic [31:0] ipv4_address
);

    logic byte_take;
    assign byte_take = byte_valid & ~byte_stall;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status) && $stable(ipv4_address))
        else $error("stalled result changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status <= ST_NO_A)
        else $error("status out of range");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_FOUND |-> ipv4_address == 32'd0)
        else $error("address set without a found record");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_take && end_of_packet |=> result_valid)
        else $error("final byte gave no result");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_take && end_of_packet))
        else $error("result without a final byte");

endmodule

bind dns_a_record_extractor dnsa_checker u_dnsa_checker (.*);

/* dv/dns_a_record_checker.sv */
`timescale 1ns / 1ps

module dns_a_record_checker
    import dnsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  packet_byte,
    input  logic        end_of_packet,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  status,
    input  logic [31:0] ipv4_address,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        status_t     code;
        logic [31:0] addr;
    } dns_answer_t;

    dns_answer_t awaited_answers[$];
    dns_answer_t head;
    dns_answer_t fresh;
    int          mismatches;

    phase_t      stage;
    logic [3:0]  hdr_pos;
    logic [15:0] qd_left;
    logic [15:0] an_left;
    logic [15:0] skip_cnt;
    logic [3:0]  fix_pos;
    logic [15:0] rr_type;
    logic [15:0] rr_len;
    logic [31:0] addr_acc;
    status_t     outcome;

    task automatic clear_parser();
        stage    = PH_HEADER;
        hdr_pos  = '0;
        qd_left  = '0;
        an_left  = '0;
        skip_cnt = '0;
        fix_pos  = '0;
        rr_type  = '0;
        rr_len   = '0;
        addr_acc = '0;
        outcome  = ST_FOUND;
    endtask

    task automatic settle(input status_t s);
        outcome = s;
        stage   = PH_DONE;
    endtask

    task automatic close_record();
        an_left = an_left - 16'd1;
        if (an_left == 16'd0)
            settle(ST_NO_A);
        else
            stage = PH_ANAME;
    endtask

    task automatic name_step(input logic [7:0] b, input phase_t after_name);
        if (skip_cnt != 16'd0)
        begin
            skip_cnt = skip_cnt - 16'd1;
        end
        else if (b == 8'h00)
        begin
            stage   = after_name;
            fix_pos = '0;
        end
        else if ((b & POINTER_MASK) == POINTER_MASK)
        begin
            // pointer: one more byte then the fixed part
            stage    = after_name;
            fix_pos  = '0;
            skip_cnt = 16'd1;
        end
        else
        begin
            skip_cnt = {8'h00, b};
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (stage)
            PH_HEADER:
            begin
                case (hdr_pos)
                    HDR_IDX_FLAGS_HI: if ((b & QR_MASK) == 8'h00) outcome = ST_HDR_ERR;
                    HDR_IDX_FLAGS_LO: if ((b & RCODE_MASK) != 8'h00) outcome = ST_HDR_ERR;
                    HDR_IDX_QD_HI:    qd_left = {b, 8'h00};
                    HDR_IDX_QD_LO:    qd_left = qd_left | {8'h00, b};
                    HDR_IDX_AN_HI:    an_left = {b, 8'h00};
                    HDR_IDX_AN_LO:    an_left = an_left | {8'h00, b};
                    default: ;
                endcase
                if (hdr_pos == HDR_IDX_LAST)
                begin
                    if (outcome != ST_FOUND)
                        settle(outcome);
                    else if (an_left == 16'd0)
                        settle(ST_NO_ANS);
                    else if (qd_left == 16'd0)
                        stage = PH_ANAME;
                    else
                        stage = PH_QNAME;
                    skip_cnt = '0;
                end
                hdr_pos = hdr_pos + 4'd1;
            end
            PH_QNAME: name_step(b, PH_QFIXED);
            PH_ANAME: name_step(b, PH_AFIXED);
            PH_QFIXED:
            begin
                if (skip_cnt != 16'd0)
                begin
                    skip_cnt = skip_cnt - 16'd1;
                end
                else if (fix_pos >= QFIX_LAST)
                begin
                    qd_left = qd_left - 16'd1;
                    stage   = (qd_left == 16'd0) ? PH_ANAME : PH_QNAME;
                    fix_pos = '0;
                end
                else
                begin
                    fix_pos = fix_pos + 4'd1;
                end
            end
            PH_AFIXED:
            begin
                if (skip_cnt != 16'd0)
                begin
                    skip_cnt = skip_cnt - 16'd1;
                end
                else
                begin
                    if (fix_pos == AFIX_TY_HI)
                        rr_type = {b, 8'h00};
                    else if (fix_pos == AFIX_TY_LO)
                        rr_type = rr_type | {8'h00, b};
                    else if (fix_pos == AFIX_DL_HI)
                        rr_len = {b, 8'h00};
                    else if (fix_pos == AFIX_DL_LO)
                        rr_len = rr_len | {8'h00, b};
                    if (fix_pos >= AFIX_DL_LO)
                    begin
                        fix_pos = '0;
                        if (rr_type == TYPE_A && rr_len == LEN_A)
                        begin
                            stage    = PH_ADDR;
                            addr_acc = '0;
                        end
                        else if (rr_len == 16'd0)
                        begin
                            close_record();
                        end
                        else
                        begin
                            skip_cnt = rr_len;
                            stage    = PH_ADATA;
                        end
                    end
                    else
                    begin
                        fix_pos = fix_pos + 4'd1;
                    end
                end
            end
            PH_ADATA:
            begin
                if (skip_cnt != 16'd0)
                    skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0)
                    close_record();
            end
            PH_ADDR:
            begin
                addr_acc = {addr_acc[23:0], b};
                if (fix_pos >= ADDR_LAST)
                    settle(ST_FOUND);
                else
                    fix_pos = fix_pos + 4'd1;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parser();
            awaited_answers.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("unexpected result: status %0d, ipv4_address %h",
                           status, ipv4_address);
                    mismatches++;
                end
                else
                begin
                    head = awaited_answers.pop_front();
                    if (status !== head.code)
                    begin
                        $error("status: expected %0d, actual %0d", head.code, status);
                        mismatches++;
                    end
                    if (ipv4_address !== head.addr)
                    begin
                        $error("ipv4_address: expected %h, actual %h",
                               head.addr, ipv4_address);
                        mismatches++;
                    end
                end
            end
            if (byte_valid && !byte_stall)
            begin
                parse_byte(packet_byte);
                if (end_of_packet)
                begin
                    if (stage == PH_HEADER)
                        fresh.code = ST_SHORT;
                    else if (stage == PH_DONE)
                        fresh.code = outcome;
                    else
                        fresh.code = ST_NO_A;
                    fresh.addr = (fresh.code == ST_FOUND) ? addr_acc : 32'h0;
                    awaited_answers.push_back(fresh);
                    clear_parser();
                end
            end
            fail_count <= mismatches;
            pending    <= awaited_answers.size();
        end
    end

endmodule

/* dv/dns_a_record_extractor_tb.sv */
`timescale 1ns / 1ps

module dns_a_record_extractor_tb;
    import dnsa_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  packet_byte;
    logic        end_of_packet;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  status;
    logic [31:0] ipv4_address;

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          bytes_sent;
    int          quiet;
    bit          hold_off_req;
    bit          hold_off_done;
    logic [7:0]  pkt[$];

    dns_a_record_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .packet_byte  (packet_byte),
        .end_of_packet(end_of_packet),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .ipv4_address (ipv4_address)
    );

    dns_a_record_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .packet_byte  (packet_byte),
        .end_of_packet(end_of_packet),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .ipv4_address (ipv4_address),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        result_stall  = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("dns_a_record_extractor_tb: FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid    <= 1'b1;
        packet_byte   <= b;
        end_of_packet <= last;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    task automatic put_random(input int n);
        repeat (n) pkt.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_header(input logic [7:0] flags_hi, input logic [7:0] flags_lo,
                              input logic [15:0] qd, input logic [15:0] an);
        pkt.delete();
        put_random(2);
        pkt.push_back(flags_hi);
        pkt.push_back(flags_lo);
        put16(qd);
        put16(an);
        put_random(4);
    endtask

    task automatic put_name();
        int labels;
        int len;
        labels = $urandom_range(0, 2);
        repeat (labels)
        begin
            if ($urandom_range(19) == 0)
                len = 8'h40 | $urandom_range(1, 7);
            else
                len = $urandom_range(1, 4);
            pkt.push_back(8'(len));
            put_random(len);
        end
        if ($urandom_range(9) < 7)
        begin
            pkt.push_back(8'h00);
        end
        else
        begin
            pkt.push_back(POINTER_MASK | 8'($urandom_range(63)));
            put_random(1);
        end
    endtask

    task automatic put_answer(input logic [15:0] rtype, input logic [15:0] rlen);
        put_name();
        put16(rtype);
        put16(16'h0001);
        put_random(4);
        put16(rlen);
        put_random(rlen);
    endtask

    task automatic put_a_record(input logic [31:0] addr);
        put_answer(TYPE_A, 16'd0);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        put16(LEN_A);
        put16(addr[31:16]);
        put16(addr[15:0]);
    endtask

    task automatic send_random_packet();
        logic [7:0]  flags_hi;
        logic [7:0]  flags_lo;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] ty;
        logic [15:0] ln;
        int          keep;
        if ($urandom_range(99) < 10)
        begin
            // noise
            pkt.delete();
            put_random($urandom_range(1, 30));
        end
        else
        begin
            flags_hi = 8'($urandom_range(255));
            flags_lo = 8'($urandom_range(255));
            if ($urandom_range(9) != 0)
                flags_hi = flags_hi | QR_MASK;
            if ($urandom_range(9) != 0)
                flags_lo = flags_lo & ~RCODE_MASK;
            qd = ($urandom_range(19) == 0) ? 16'($urandom_range(16'hffff))
                                           : 16'($urandom_range(0, 2));
            an = ($urandom_range(19) == 0) ? 16'($urandom_range(16'hffff))
                                           : 16'($urandom_range(0, 3));
            put_header(flags_hi, flags_lo, qd, an);
            for (int i = 0; i < qd && i < 3; i++)
            begin
                put_name();
                put_random(4);
            end
            for (int i = 0; i < an && i < 3; i++)
            begin
                case ($urandom_range(3))
                    0, 1: ty = TYPE_A;
                    2:    ty = 16'd5;
                    default: ty = 16'($urandom_range(16'hffff));
                endcase
                if (ty == TYPE_A && $urandom_range(3) != 0)
                    ln = LEN_A;
                else
                    ln = 16'($urandom_range(0, 6));
                put_answer(ty, ln);
            end
            put_random($urandom_range(0, 3));
            if ($urandom_range(99) < 15)
            begin
                keep = $urandom_range(1, pkt.size());
                while (pkt.size() > keep) void'(pkt.pop_back());
            end
        end
        send_packet();
    endtask

    task automatic run_directed();
        // one byte, then eleven: both short of a header
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet();
        pkt.delete();
        put_random(11);
        send_packet();

        // QR clear
        put_header(8'h00, 8'h00, 16'd0, 16'd1);
        send_packet();
        // RCODE fault wins over zero answers
        put_header(8'hff, 8'hff, 16'd0, 16'd0);
        send_packet();
        put_header(8'h80, 8'h01, 16'd0, 16'd1);
        send_packet();
        put_header(8'h80, 8'h00, 16'd1, 16'd0);
        send_packet();

        // long labels with top bits 10 and 01, then bytes after the capture
        put_header(8'h81, 8'h80, 16'd1, 16'd1);
        pkt.push_back(8'h80);
        put_random(128);
        pkt.push_back(8'h40);
        put_random(64);
        pkt.push_back(8'h00);
        put_random(4);
        put_a_record(32'hffff_ffff);
        pkt.push_back(8'hff);
        pkt.push_back(8'h00);
        pkt.push_back(8'hc0);
        send_packet();

        // no questions; other record, zero-length A, then the address
        put_header(8'h80, 8'h00, 16'd0, 16'd3);
        put_answer(16'd5, 16'd3);
        put_answer(TYPE_A, 16'd0);
        put_a_record(32'h0000_0000);
        send_packet();

        // pointer-terminated question names
        put_header(8'h84, 8'h00, 16'd2, 16'd1);
        pkt.push_back(8'hc0);
        pkt.push_back(8'h0c);
        put_random(4);
        pkt.push_back(8'h03);
        put_random(3);
        pkt.push_back(8'hff);
        pkt.push_back(8'hff);
        put_random(4);
        put_a_record(32'hc0a8_0001);
        send_packet();

        // answers run out with no A record
        put_header(8'h80, 8'h00, 16'd0, 16'd2);
        put_answer(16'd28, 16'd16);
        put_answer(TYPE_A, 16'd5);
        send_packet();

        // ends inside a question
        put_header(8'h80, 8'h00, 16'd1, 16'd1);
        pkt.push_back(8'h05);
        put_random(2);
        send_packet();

        // ends in a partial address
        put_header(8'h80, 8'h00, 16'd0, 16'd1);
        put_a_record(32'h0a0b_0c0d);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        send_packet();

        // ends in record data
        put_header(8'h80, 8'h00, 16'd0, 16'd1);
        put_answer(16'd5, 16'd6);
        void'(pkt.pop_back());
        send_packet();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        packet_byte   = 8'h00;
        end_of_packet = 1'b0;
        hold_off_req  = 1'b0;
        bytes_sent    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 47;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        while (bytes_sent < 600) send_random_packet();

        // long receiver hold-off while one-byte requests keep coming
        hold_off_req = 1'b1;
        repeat (24)
        begin
            pkt.delete();
            put_random(1);
            send_packet();
        end

        send_idle_pct = 47;
        recv_idle_pct = 11;
        while (bytes_sent < 1150) send_random_packet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent < 1750) send_random_packet();

        byte_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("dns_a_record_extractor_tb: PASS");
        else
            $display("dns_a_record_extractor_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dnsa_pkg.sv
hw/rtl/dns_a_record_extractor.sv
hw/rtl/dnsa_checker.sv
dv/dns_a_record_checker.sv
dv/dns_a_record_extractor_tb.sv
